@@ hw/rtl/smrm_pkg.sv @@
// shared types and constants of the seed match region merger
package smrm_pkg;

	localparam int MAX_OPEN = 16;
	localparam int MAX_RESULTS = 16;
	localparam int OPEN_CAP = (MAX_OPEN < MAX_RESULTS) ? MAX_OPEN : (MAX_RESULTS - 1);
	localparam int UW = $clog2(OPEN_CAP + 1);
	localparam int IW = $clog2(OPEN_CAP);

	localparam logic REG_SEED_LENGTH = 1'b0;

	typedef logic [UW-1:0] used_t;

	typedef struct packed {
		logic [15:0] qs;
		logic [15:0] qe;
		logic [31:0] rs;
		logic [31:0] re;
		logic [15:0] qlast;
		logic [31:0] rlast;
		logic [15:0] cnt;
		logic [31:0] refnum;
		logic        strand;
	} region_t;

	typedef struct packed {
		logic latch;
		logic eval;
		logic commit;
		logic merge;
		logic scan;
		logic pop;
		logic forced;
		logic insert;
		logic gclear;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic  redundant;
		logic  hit;
		logic  do_filter;
		logic  glast;
		used_t used;
	} status_t;

endpackage

@@ hw/rtl/smrm_datapath.sv @@
// datapath: open region table, match compare, emit and score pipeline
module smrm_datapath
	import smrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [7:0]  seed_length,
	input  logic [15:0] qry_begin,
	input  logic [15:0] qry_end,
	input  logic [31:0] ref_begin,
	input  logic [31:0] ref_end,
	input  logic [31:0] reference_number,
	input  logic        reverse_strand,
	input  logic        group_last,
	input  logic        read_first,
	output status_t     status,
	output logic        result_valid,
	output logic [15:0] out_query_start,
	output logic [15:0] out_query_end,
	output logic [31:0] out_ref_start,
	output logic [31:0] out_ref_end,
	output logic [31:0] out_reference_number,
	output logic        out_reverse_strand,
	output logic [15:0] match_count,
	output logic [31:0] region_score,
	output logic [15:0] region_id,
	output logic        forced_out,
	output logic        last_result
);

	region_t tab_q [OPEN_CAP];
	used_t   used_q;

	logic [15:0] qs_q, qe_q;
	logic [31:0] rs_q, re_q, refnum_q;
	logic        strand_q, glast_q;

	logic [15:0] prev_qs_q, prev_qe_q, filt_q, emit_cnt_q;
	logic [31:0] prev_rs_q, prev_re_q;

	logic [OPEN_CAP-1:0] hit_q, ext_q, cand, ext, hit_vec;
	logic                hit_any_q, red_q, dof_q;

	region_t     pend_q;
	logic        pend_v_q, pend_dpos_q, pend_forced_q;
	logic [15:0] pend_d_q, pend_id_q;

	region_t     e0, new_r;
	logic        passed, emit_now, redundant, do_filter;
	used_t       tail;
	logic [16:0] qspan17;
	logic signed [33:0] qsp, rsp, mx, mn;
	logic signed [34:0] dd;
	logic        dpos;
	logic [31:0] prod;

	always_comb begin
		for (int j = 0; j < OPEN_CAP; j++) begin
			ext[j] = (qe_q > tab_q[j].qe) && (re_q > tab_q[j].re);
			cand[j] = (UW'(j) < used_q) && (tab_q[j].refnum == refnum_q)
				&& (tab_q[j].strand == strand_q)
				&& (tab_q[j].qlast <= qs_q) && (qs_q <= tab_q[j].qe)
				&& (tab_q[j].rlast <= rs_q) && (rs_q <= tab_q[j].re)
				&& (ext[j] || ((qe_q <= tab_q[j].qe) && (re_q <= tab_q[j].re)));
		end
		hit_vec = cand & (~cand + 1'b1);
	end

	assign qspan17 = {1'b0, qe_q} - {1'b0, qs_q};
	assign redundant = ((qs_q == prev_qs_q) && (qe_q == prev_qe_q)
		&& (rs_q == prev_rs_q) && (re_q == prev_re_q))
		|| ((qspan17 == {9'b0, seed_length}) && (qs_q == prev_qs_q) && (rs_q == prev_rs_q));
	assign do_filter = {1'b0, qs_q} > ({1'b0, filt_q} + {9'b0, seed_length});

	assign e0 = tab_q[0];
	assign passed = e0.qe < qs_q;
	assign tail = used_q - 1'b1;
	assign emit_now = (cmd.scan && passed) || cmd.pop;

	always_comb begin
		new_r.qs = qs_q;
		new_r.qe = qe_q;
		new_r.rs = rs_q;
		new_r.re = re_q;
		new_r.qlast = qs_q;
		new_r.rlast = rs_q;
		new_r.cnt = 16'd1;
		new_r.refnum = refnum_q;
		new_r.strand = strand_q;
	end

	always_comb begin
		qsp = $signed({18'b0, e0.qe}) - $signed({18'b0, e0.qs});
		rsp = $signed({2'b0, e0.re}) - $signed({2'b0, e0.rs});
		mx = (qsp > rsp) ? qsp : rsp;
		mn = (qsp < rsp) ? qsp : rsp;
		dd = $signed({mn, 1'b0}) - $signed({mx[33], mx});
		dpos = !dd[34] && (dd != '0);
	end

	assign prod = 32'(pend_q.cnt) * 32'(pend_d_q);

	// region table
	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			for (int j = 0; j < OPEN_CAP; j++) begin
				if (hit_q[j]) begin
					if (ext_q[j]) begin
						tab_q[j].qe <= qe_q;
						tab_q[j].re <= re_q;
					end
					tab_q[j].qlast <= qs_q;
					tab_q[j].rlast <= rs_q;
					if (tab_q[j].cnt != 16'hFFFF) begin
						tab_q[j].cnt <= tab_q[j].cnt + 16'd1;
					end
				end
			end
		end else if (cmd.scan || cmd.pop) begin
			for (int j = 0; j < OPEN_CAP - 1; j++) begin
				if (cmd.scan && !passed && (UW'(j) == tail)) begin
					tab_q[j] <= e0;
				end else begin
					tab_q[j] <= tab_q[j+1];
				end
			end
			if (cmd.scan && !passed && (tail == UW'(OPEN_CAP - 1))) begin
				tab_q[OPEN_CAP-1] <= e0;
			end
		end else if (cmd.insert) begin
			tab_q[used_q[IW-1:0]] <= new_r;
		end
	end

	// input, evaluation and pending emit registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			qs_q <= qry_begin;
			qe_q <= qry_end;
			rs_q <= ref_begin;
			re_q <= ref_end;
			refnum_q <= reference_number;
			strand_q <= reverse_strand;
			glast_q <= group_last;
		end
		if (cmd.eval) begin
			hit_q <= hit_vec;
			ext_q <= ext;
			hit_any_q <= |cand;
			red_q <= redundant;
			dof_q <= do_filter;
		end
		if (emit_now) begin
			pend_q <= e0;
			pend_d_q <= dd[15:0];
			pend_dpos_q <= dpos;
			pend_forced_q <= cmd.forced;
			pend_id_q <= emit_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			prev_qs_q <= '0;
			prev_qe_q <= '0;
			prev_rs_q <= '0;
			prev_re_q <= '0;
			filt_q <= '0;
			emit_cnt_q <= '0;
			pend_v_q <= 1'b0;
			result_valid <= 1'b0;
			last_result <= 1'b0;
		end else begin
			if ((cmd.scan && passed) || cmd.pop) begin
				used_q <= used_q - 1'b1;
			end else if (cmd.insert) begin
				used_q <= used_q + 1'b1;
			end else if (cmd.gclear) begin
				used_q <= '0;
			end
			if (cmd.gclear) begin
				prev_qs_q <= '0;
				prev_qe_q <= '0;
				prev_rs_q <= '0;
				prev_re_q <= '0;
				filt_q <= '0;
			end else if (cmd.commit) begin
				prev_qs_q <= qs_q;
				prev_qe_q <= qe_q;
				prev_rs_q <= rs_q;
				prev_re_q <= re_q;
				if (dof_q) begin
					filt_q <= qs_q;
				end
			end
			if (cmd.latch && read_first) begin
				emit_cnt_q <= '0;
			end else if (emit_now) begin
				emit_cnt_q <= emit_cnt_q + 16'd1;
			end
			if (emit_now) begin
				pend_v_q <= 1'b1;
				result_valid <= pend_v_q;
				last_result <= 1'b0;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
				result_valid <= pend_v_q;
				last_result <= pend_v_q;
			end else begin
				result_valid <= 1'b0;
				last_result <= 1'b0;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if ((emit_now || cmd.finish) && pend_v_q) begin
			out_query_start <= pend_q.qs;
			out_query_end <= pend_q.qe;
			out_ref_start <= pend_q.rs;
			out_ref_end <= pend_q.re;
			out_reference_number <= pend_q.refnum;
			out_reverse_strand <= pend_q.strand;
			match_count <= pend_q.cnt;
			region_score <= pend_dpos_q ? prod : 32'd1;
			region_id <= pend_id_q;
			forced_out <= pend_forced_q;
		end
	end

	assign status.redundant = red_q;
	assign status.hit = hit_any_q;
	assign status.do_filter = dof_q;
	assign status.glast = glast_q;
	assign status.used = used_q;

endmodule

@@ hw/rtl/smrm_ctrl.sv @@
// controller: sequences evaluate, merge, filter, insert and flush steps
module smrm_ctrl
	import smrm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output logic    busy,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_EVAL, S_DECIDE, S_FILT1, S_FORCE, S_INSERT,
		S_FILT2, S_TAIL, S_FLUSH, S_DONE
	} state_t;

	state_t state_q, state_d;
	used_t  cnt_q, cnt_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.redundant) begin
					state_d = status.glast ? S_FLUSH : S_DONE;
				end else begin
					cmd.commit = 1'b1;
					cmd.merge = status.hit;
					if (status.do_filter) begin
						cnt_d = status.used;
						state_d = S_FILT1;
					end else begin
						state_d = status.hit ? S_TAIL : S_FORCE;
					end
				end
			end
			S_FILT1: begin
				if (cnt_q != '0) begin
					cmd.scan = 1'b1;
					cnt_d = cnt_q - 1'b1;
				end else begin
					state_d = status.hit ? S_TAIL : S_FORCE;
				end
			end
			S_FORCE: begin
				if (status.used >= UW'(OPEN_CAP)) begin
					cmd.pop = 1'b1;
					cmd.forced = 1'b1;
				end
				state_d = S_INSERT;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				if (status.do_filter) begin
					cnt_d = status.used + 1'b1;
					state_d = S_FILT2;
				end else begin
					state_d = S_TAIL;
				end
			end
			S_FILT2: begin
				if (cnt_q != '0) begin
					cmd.scan = 1'b1;
					cnt_d = cnt_q - 1'b1;
				end else begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = status.glast ? S_FLUSH : S_DONE;
			end
			S_FLUSH: begin
				if (status.used != '0) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.gclear = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ hw/rtl/seed_match_region_merger_unit.sv @@
// top level of the seed match region merger
// A match transaction is taken at a rising edge with start high and busy low.
// Results leave one per cycle on the result ports, marked by result_valid;
// the receiver cannot stall them. last_result marks the final result of a
// match and comes in the first cycle with busy low after that match.
// A dropped match steps through accept, compare, decide and done; a merge
// with no filter pass adds a wrap-up step. Each filter scan (up to two per
// match) scans every open region and then leaves the scan, a new region
// adds a full-table check and an insert, and a group end pops every open
// region and then clears the group. The time a match takes is set by the
// serial scans of the open table of up to 15 regions.
// Each emitted region is held one stage and reaches the port in the cycle
// after the next emission or after the done step.
// seed_length is written over the APB port at byte address 0; the user
// must write it only while busy is low, which the block does not enforce.
// Reset clears the open table count, the previous match, the filter point,
// the region id counter and sets seed_length to 20.
module seed_match_region_merger_unit
	import smrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] qry_begin,
	input  logic [15:0] qry_end,
	input  logic [31:0] ref_begin,
	input  logic [31:0] ref_end,
	input  logic [31:0] reference_number,
	input  logic        reverse_strand,
	input  logic        group_last,
	input  logic        read_first,
	output logic        result_valid,
	output logic [15:0] out_query_start,
	output logic [15:0] out_query_end,
	output logic [31:0] out_ref_start,
	output logic [31:0] out_ref_end,
	output logic [31:0] out_reference_number,
	output logic        out_reverse_strand,
	output logic [15:0] match_count,
	output logic [31:0] region_score,
	output logic [15:0] region_id,
	output logic        forced_out,
	output logic        last_result
);

	logic [7:0] seed_length_q;
	cmd_t       cmd;
	status_t    status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_length_q <= 8'd20;
		end else if (psel && penable && pwrite && (paddr[2] == REG_SEED_LENGTH)) begin
			seed_length_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_SEED_LENGTH) ? {24'b0, seed_length_q} : 32'b0;

	smrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	smrm_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.seed_length          (seed_length_q),
		.qry_begin            (qry_begin),
		.qry_end              (qry_end),
		.ref_begin            (ref_begin),
		.ref_end              (ref_end),
		.reference_number     (reference_number),
		.reverse_strand       (reverse_strand),
		.group_last           (group_last),
		.read_first           (read_first),
		.status               (status),
		.result_valid         (result_valid),
		.out_query_start      (out_query_start),
		.out_query_end        (out_query_end),
		.out_ref_start        (out_ref_start),
		.out_ref_end          (out_ref_end),
		.out_reference_number (out_reference_number),
		.out_reverse_strand   (out_reverse_strand),
		.match_count          (match_count),
		.region_score         (region_score),
		.region_id            (region_id),
		.forced_out           (forced_out),
		.last_result          (last_result)
	);

endmodule

@@ hw/rtl/smrm_checker.sv @@
// port-level checker of the seed match region merger and its bind
module smrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic        last_result,
	input logic [15:0] match_count,
	input logic [31:0] region_score
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> !busy)
		else $error("last result while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("intermediate result outside a transaction");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (match_count != 16'd0) && (region_score != 32'd0))
		else $error("zero count or score on result");

endmodule

bind seed_match_region_merger_unit smrm_checker u_smrm_checker (.*);
